@@ src/cmt_pkg.sv @@
package cmt_pkg;

    localparam int unsigned PRESCALER_WIDTH = 9;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [2:0] REG_START    = 3'd0;
    localparam logic [2:0] REG_CSR0     = 3'd1;
    localparam logic [2:0] REG_COUNT0   = 3'd2;
    localparam logic [2:0] REG_COMPARE0 = 3'd3;
    localparam logic [2:0] REG_CSR1     = 3'd4;
    localparam logic [2:0] REG_COUNT1   = 3'd5;
    localparam logic [2:0] REG_COMPARE1 = 3'd6;
    localparam logic [2:0] REG_NONE     = 3'd7;

    localparam logic [1:0] LANE_WORD = 2'd0;
    localparam logic [1:0] LANE_HIGH = 2'd1;
    localparam logic [1:0] LANE_LOW  = 2'd2;

    localparam logic [15:0] MASK_WORD = 16'hFFFF;
    localparam logic [15:0] MASK_LOW  = 16'h00FF;
    localparam logic [15:0] MASK_HIGH = 16'hFF00;

    localparam logic [15:0] MATCH_RESET = 16'hFFFF;
    localparam logic [15:0] UNUSED_READ = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  reg_index;
        logic [1:0]  byte_lane;
        logic [15:0] write_data;
    } cmt_in_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_channel0;
        logic        irq_channel1;
    } cmt_out_t;

    // Per-channel operation for the transaction being executed
    typedef struct packed {
        logic        tick;
        logic        csr_wr;
        logic        csr_rd;
        logic [15:0] cnt_mask;
        logic [15:0] cmp_mask;
        logic [15:0] wdata;
    } cmt_ctrl_t;

    typedef struct packed {
        logic [7:0]  csr;
        logic [1:0]  clock_select;
        logic [15:0] count;
        logic [15:0] match;
        logic        irq;
        logic        irq_next;
    } cmt_stat_t;

    // Low bits of the prescaler that must be zero for a count boundary.
    function automatic logic [PRESCALER_WIDTH-1:0] div_mask(input logic [1:0] cs);
        logic [PRESCALER_WIDTH-1:0] m;
        int unsigned sh;
        sh = 3 + 2 * int'(cs);
        for (int unsigned i = 0; i < PRESCALER_WIDTH; i++)
        begin
            m[i] = (i < sh);
        end
        return m;
    endfunction

endpackage

@@ src/two_channel_compare_match_timer.sv @@
// Two-channel compare match timer.
// in_valid/in_ready carry one transaction: a tick (one peripheral clock
// state), a register read or a register write, packed as cmt_in_t.
// out_valid/out_ready return exactly one cmt_out_t per transaction: read
// data (zero for ticks and writes) and both interrupt requests as they
// stand after the transaction.
// From input acceptance to out_valid a transaction passes the input
// register, then the execute stage that updates the timer state and loads
// the result register. Throughput is one transaction per cycle unless a stall holds it.
// When out_ready is low with a result pending, the result register holds,
// the execute stage stalls with the timer state frozen, and in_ready stays
// high until the input register is also occupied.
// Reset clears the prescaler, start bits, flags, enables, clock selects
// and counters, sets both compare registers to 0xFFFF, and empties both
// pipeline registers.
module two_channel_compare_match_timer
    import cmt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cmt_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output cmt_out_t out_data
);

    cmt_in_t  in_reg;
    logic     in_valid_reg;
    cmt_out_t out_reg, out_next;
    logic     out_valid_reg;
    logic     advance;
    logic     exec;

    logic [PRESCALER_WIDTH-1:0] psc_reg, psc_next;
    logic [1:0]                 start_reg, start_next;

    cmt_ctrl_t  ctrl0, ctrl1;
    cmt_stat_t  stat0, stat1;
    logic [15:0] wmask;
    logic [15:0] rd_word;
    logic        is_tick, is_read, is_write;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign exec      = in_valid_reg && advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
    end

    assign is_tick  = (in_reg.opcode == OP_TICK);
    assign is_read  = (in_reg.opcode == OP_READ);
    assign is_write = (in_reg.opcode == OP_WRITE);

    always_comb
    begin
        case (in_reg.byte_lane)
            LANE_HIGH: wmask = MASK_HIGH;
            LANE_LOW:  wmask = MASK_LOW;
            default:   wmask = MASK_WORD;
        endcase
    end

    assign psc_next = is_tick ? psc_reg + 1'b1 : psc_reg;
    assign start_next = (is_write && in_reg.reg_index == REG_START && wmask[0])
                        ? in_reg.write_data[1:0] : start_reg;

    always_comb
    begin
        ctrl0.tick     = is_tick && start_reg[0]
                         && ((psc_next & div_mask(stat0.clock_select)) == '0);
        ctrl0.csr_wr   = is_write && in_reg.reg_index == REG_CSR0 && wmask[0];
        ctrl0.csr_rd   = is_read && in_reg.reg_index == REG_CSR0;
        ctrl0.cnt_mask = (is_write && in_reg.reg_index == REG_COUNT0) ? wmask : '0;
        ctrl0.cmp_mask = (is_write && in_reg.reg_index == REG_COMPARE0) ? wmask : '0;
        ctrl0.wdata    = in_reg.write_data;

        ctrl1.tick     = is_tick && start_reg[1]
                         && ((psc_next & div_mask(stat1.clock_select)) == '0);
        ctrl1.csr_wr   = is_write && in_reg.reg_index == REG_CSR1 && wmask[0];
        ctrl1.csr_rd   = is_read && in_reg.reg_index == REG_CSR1;
        ctrl1.cnt_mask = (is_write && in_reg.reg_index == REG_COUNT1) ? wmask : '0;
        ctrl1.cmp_mask = (is_write && in_reg.reg_index == REG_COMPARE1) ? wmask : '0;
        ctrl1.wdata    = in_reg.write_data;
    end

    cmt_channel u_ch0
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (exec),
        .ctrl  (ctrl0),
        .stat  (stat0)
    );

    cmt_channel u_ch1
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (exec),
        .ctrl  (ctrl1),
        .stat  (stat1)
    );

    always_comb
    begin
        case (in_reg.reg_index)
            REG_START:    rd_word = {14'd0, start_reg};
            REG_CSR0:     rd_word = {8'd0, stat0.csr};
            REG_COUNT0:   rd_word = stat0.count;
            REG_COMPARE0: rd_word = stat0.match;
            REG_CSR1:     rd_word = {8'd0, stat1.csr};
            REG_COUNT1:   rd_word = stat1.count;
            REG_COMPARE1: rd_word = stat1.match;
            default:      rd_word = UNUSED_READ;
        endcase
    end

    always_comb
    begin
        out_next.read_data = '0;
        if (is_read)
        begin
            case (in_reg.byte_lane)
                LANE_HIGH: out_next.read_data = {8'd0, rd_word[15:8]};
                LANE_LOW:  out_next.read_data = {8'd0, rd_word[7:0]};
                default:   out_next.read_data = rd_word;
            endcase
        end
        out_next.irq_channel0 = stat0.irq_next;
        out_next.irq_channel1 = stat1.irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psc_reg       <= '0;
            start_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                psc_reg   <= psc_next;
                start_reg <= start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_reg <= out_next;
        end
    end

    // prescaler only moves on executed tick transactions
    assert property (@(posedge clk) disable iff (!rst_n)
        !(exec && is_tick) |=> $stable(psc_reg))
        else $error("prescaler moved without a tick");

    // a pending result reflects the current interrupt state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.irq_channel0 == stat0.irq)
                          && (out_reg.irq_channel1 == stat1.irq))
        else $error("result irq out of step with channel state");

    // a result only appears from an occupied input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result produced without a transaction");

    // a stalled input transaction is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled transaction lost");

endmodule

@@ src/cmt_channel.sv @@
module cmt_channel
    import cmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  cmt_ctrl_t ctrl,
    output cmt_stat_t stat
);

    logic        flag_reg, flag_next;
    logic        seen_reg, seen_next;
    logic        irq_en_reg, irq_en_next;
    logic [1:0]  cs_reg, cs_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] match_reg, match_next;

    always_comb
    begin
        flag_next   = flag_reg;
        seen_next   = seen_reg;
        irq_en_next = irq_en_reg;
        cs_next     = cs_reg;
        count_next  = (count_reg & ~ctrl.cnt_mask) | (ctrl.wdata & ctrl.cnt_mask);
        match_next  = (match_reg & ~ctrl.cmp_mask) | (ctrl.wdata & ctrl.cmp_mask);
        if (ctrl.tick)
        begin
            if (count_reg == match_reg)
            begin
                count_next = '0;
                flag_next  = 1'b1;
            end
            else
            begin
                count_next = count_reg + 16'd1;
            end
        end
        if (ctrl.csr_wr)
        begin
            // flag clears only on a 0 write after a CSR read while it was 1
            if (!ctrl.wdata[7] && seen_reg)
            begin
                flag_next = 1'b0;
            end
            seen_next   = 1'b0;
            irq_en_next = ctrl.wdata[6];
            cs_next     = ctrl.wdata[1:0];
        end
        if (ctrl.csr_rd && flag_reg)
        begin
            seen_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg   <= 1'b0;
            seen_reg   <= 1'b0;
            irq_en_reg <= 1'b0;
            cs_reg     <= 2'd0;
            count_reg  <= '0;
            match_reg  <= MATCH_RESET;
        end
        else if (en)
        begin
            flag_reg   <= flag_next;
            seen_reg   <= seen_next;
            irq_en_reg <= irq_en_next;
            cs_reg     <= cs_next;
            count_reg  <= count_next;
            match_reg  <= match_next;
        end
    end

    assign stat.csr          = {flag_reg, irq_en_reg, 4'd0, cs_reg};
    assign stat.clock_select = cs_reg;
    assign stat.count        = count_reg;
    assign stat.match        = match_reg;
    assign stat.irq          = flag_reg & irq_en_reg;
    assign stat.irq_next     = flag_next & irq_en_next;

endmodule

@@ tb/testbench.sv @@
module testbench;
    import cmt_pkg::*;

    // encodings the package leaves unnamed; the block must tolerate them
    localparam logic [1:0] OP_NOP   = 2'd3;
    localparam logic [1:0] LANE_ALT = 2'd3;

    localparam int ITEM_TARGET  = 1900;
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_REPORTS  = 10;

    class timer_checker;
        // mirror of the timer state
        logic [PRESCALER_WIDTH-1:0] psc;
        logic [1:0]                 run_bits;
        logic                       flag [2];
        logic                       ien [2];
        logic [1:0]                 csel [2];
        logic [15:0]                count [2];
        logic [15:0]                match [2];
        logic                       seen [2];

        cmt_out_t pending_responses[$];

        int n_ticks, n_reads, n_writes, n_other;
        int n_matches, n_clears, n_checked, n_errors;

        function new();
            psc = '0;
            run_bits = '0;
            for (int c = 0; c < 2; c++)
            begin
                flag[c] = 1'b0;
                ien[c] = 1'b0;
                csel[c] = 2'd0;
                count[c] = 16'h0000;
                match[c] = MATCH_RESET;
                seen[c] = 1'b0;
            end
        endfunction

        function int pending();
            return pending_responses.size();
        endfunction

        function void prescale_tick();
            int unsigned shift;
            logic        hit;
            psc = psc + 1'b1;
            for (int c = 0; c < 2; c++)
            begin
                shift = 3 + 2 * csel[c];
                // divisor as wide as the prescaler: only the wrap counts
                if (shift >= PRESCALER_WIDTH)
                    hit = (psc == '0);
                else
                    hit = ((psc & ((1 << shift) - 1)) == 0);
                if (run_bits[c] && hit)
                begin
                    if (count[c] == match[c])
                    begin
                        count[c] = 16'h0000;
                        flag[c] = 1'b1;
                        n_matches++;
                    end
                    else
                        count[c] = count[c] + 16'd1;
                end
            end
        endfunction

        function logic [15:0] reg_read_value(logic [2:0] idx);
            int c;
            c = (idx >= REG_CSR1) ? 1 : 0;
            case (idx)
                REG_START: return {14'd0, run_bits};
                REG_CSR0, REG_CSR1:
                begin
                    if (flag[c])
                        seen[c] = 1'b1;
                    return {8'd0, flag[c], ien[c], 4'd0, csel[c]};
                end
                REG_COUNT0, REG_COUNT1:     return count[c];
                REG_COMPARE0, REG_COMPARE1: return match[c];
                default:                    return UNUSED_READ;
            endcase
        endfunction

        function void reg_write_apply(logic [2:0] idx, logic [15:0] mask, logic [15:0] data);
            int          c;
            logic [15:0] v;
            c = (idx >= REG_CSR1) ? 1 : 0;
            v = data & mask;
            case (idx)
                REG_START:
                    if ((mask & MASK_LOW) != 0)
                        run_bits = v[1:0];
                REG_CSR0, REG_CSR1:
                    if ((mask & MASK_LOW) != 0)
                    begin
                        // clear needs a prior CSR read while the flag was set
                        if (!v[7] && seen[c])
                        begin
                            if (flag[c])
                                n_clears++;
                            flag[c] = 1'b0;
                        end
                        seen[c] = 1'b0;
                        ien[c] = v[6];
                        csel[c] = v[1:0];
                    end
                REG_COUNT0, REG_COUNT1:     count[c] = (count[c] & ~mask) | v;
                REG_COMPARE0, REG_COMPARE1: match[c] = (match[c] & ~mask) | v;
                default: ;
            endcase
        endfunction

        function void note_transaction(cmt_in_t t);
            cmt_out_t    r;
            logic [15:0] mask;
            logic [15:0] v;
            r = '0;
            mask = (t.byte_lane == LANE_HIGH) ? MASK_HIGH :
                   (t.byte_lane == LANE_LOW)  ? MASK_LOW  : MASK_WORD;
            case (t.opcode)
                OP_TICK:
                begin
                    prescale_tick();
                    n_ticks++;
                end
                OP_READ:
                begin
                    v = reg_read_value(t.reg_index);
                    if (t.byte_lane == LANE_HIGH)
                        r.read_data = v >> 8;
                    else if (t.byte_lane == LANE_LOW)
                        r.read_data = v & MASK_LOW;
                    else
                        r.read_data = v;
                    n_reads++;
                end
                OP_WRITE:
                begin
                    reg_write_apply(t.reg_index, mask, t.write_data);
                    n_writes++;
                end
                default: n_other++;
            endcase
            r.irq_channel0 = flag[0] & ien[0];
            r.irq_channel1 = flag[1] & ien[1];
            pending_responses.push_back(r);
        endfunction

        function void check_response(cmt_out_t got);
            cmt_out_t want;
            if (pending_responses.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected response rd=%h irq0=%b irq1=%b",
                             got.read_data, got.irq_channel0, got.irq_channel1);
                return;
            end
            want = pending_responses.pop_front();
            n_checked++;
            if (got.read_data !== want.read_data ||
                got.irq_channel0 !== want.irq_channel0 ||
                got.irq_channel1 !== want.irq_channel1)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("response %0d: expected rd=%h irq0=%b irq1=%b, got rd=%h irq0=%b irq1=%b",
                             n_checked, want.read_data, want.irq_channel0,
                             want.irq_channel1, got.read_data, got.irq_channel0,
                             got.irq_channel1);
            end
        endfunction

        function void flush_leftovers();
            if (pending_responses.size() != 0)
            begin
                n_errors += pending_responses.size();
                $display("%0d responses never arrived", pending_responses.size());
                pending_responses.delete();
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    cmt_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    cmt_out_t out_data;

    timer_checker sb = new();

    int sent_count   = 0;
    int hold_request = 0;
    bit idling_on    = 1'b1;

    two_channel_compare_match_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_transaction(in_data);
            if (out_valid && out_ready)
                sb.check_response(out_data);
        end
    end

    // response side: random backpressure plus one long hold on request
    initial
    begin
        int burst;
        int hold_left;
        burst = 0;
        hold_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (burst > 0)
            begin
                burst--;
                out_ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("testbench failed");
        $finish;
    end

    task automatic send_txn(input logic [1:0] op, input logic [2:0] idx,
                            input logic [1:0] lane, input logic [15:0] data);
        cmt_in_t t;
        int      gap;
        t.opcode = op;
        t.reg_index = idx;
        t.byte_lane = lane;
        t.write_data = data;
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= t;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
    endtask

    task automatic wait_drained(input int limit);
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    function automatic logic [1:0] pick_cs();
        int r;
        r = $urandom_range(0, 99);
        return (r < 70) ? 2'd0 : (r < 90) ? 2'd1 : (r < 97) ? 2'd2 : 2'd3;
    endfunction

    function automatic logic [1:0] pick_lane();
        int r;
        r = $urandom_range(0, 19);
        return (r < 12) ? LANE_WORD : (r < 16) ? LANE_LOW : (r < 19) ? LANE_HIGH : LANE_ALT;
    endfunction

    initial
    begin
        int          pick;
        int          ch;
        int          n;
        bit          pressure_done;
        bit          pause_done;
        logic [15:0] d;

        pressure_done = 1'b0;
        pause_done = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset values, unused index, lane handling, flag protocol
        send_txn(OP_READ, REG_NONE, LANE_WORD, 16'h0000);
        send_txn(OP_READ, REG_NONE, LANE_LOW, 16'hFFFF);
        send_txn(OP_READ, REG_COMPARE0, LANE_HIGH, 16'h0000);
        send_txn(OP_WRITE, REG_COMPARE0, LANE_WORD, 16'h0000);
        send_txn(OP_WRITE, REG_CSR0, LANE_LOW, 16'h00C0);   // flag bit 1 must not set it
        send_txn(OP_WRITE, REG_START, LANE_HIGH, 16'hFF00); // reserved byte
        send_txn(OP_WRITE, REG_START, LANE_WORD, 16'hFFFF);
        send_txn(OP_WRITE, REG_COUNT1, LANE_WORD, 16'hFFFF);
        send_txn(OP_WRITE, REG_COMPARE1, LANE_LOW, 16'h0005); // counter above compare
        repeat (8) send_txn(OP_TICK, REG_NONE, LANE_WORD, 16'h0000);
        send_txn(OP_READ, REG_CSR1, LANE_HIGH, 16'h0000);
        send_txn(OP_WRITE, REG_CSR0, LANE_WORD, 16'h0040);  // flag not yet seen: stays
        send_txn(OP_READ, REG_CSR0, LANE_LOW, 16'h0000);
        send_txn(OP_WRITE, REG_CSR0, LANE_HIGH, 16'h0000);
        send_txn(OP_WRITE, REG_CSR0, LANE_WORD, 16'hFF41);
        send_txn(OP_NOP, REG_COUNT0, LANE_ALT, 16'hFFFF);
        send_txn(OP_READ, REG_COUNT0, LANE_ALT, 16'h0000);
        send_txn(OP_WRITE, REG_NONE, LANE_WORD, 16'hFFFF);
        send_txn(OP_WRITE, REG_COUNT0, LANE_ALT, 16'h1234);
        send_txn(OP_READ, REG_START, LANE_WORD, 16'h0000);

        while (sent_count < ITEM_TARGET)
        begin
            if (!pressure_done && sent_count >= 600)
            begin
                pressure_done = 1'b1;
                hold_request = 40;
            end
            if (!pause_done && sent_count >= 1200)
            begin
                pause_done = 1'b1;
                wait_drained(5000);
            end
            if (sent_count >= ITEM_TARGET - 300)
                idling_on = 1'b0;

            pick = $urandom_range(0, 99);
            ch = $urandom_range(0, 1);
            if (pick < 30)
            begin
                // set up one channel: compare, counter, control, start
                d = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 12)) : 16'($urandom);
                send_txn(OP_WRITE, ch ? REG_COMPARE1 : REG_COMPARE0, pick_lane(), d);
                d = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
                send_txn(OP_WRITE, ch ? REG_COUNT1 : REG_COUNT0, pick_lane(), d);
                d = {8'($urandom), 1'($urandom), 1'($urandom_range(0, 3) != 0),
                     4'($urandom), pick_cs()};
                send_txn(OP_WRITE, ch ? REG_CSR1 : REG_CSR0, pick_lane(), d);
                d = {14'($urandom), ($urandom_range(0, 9) < 7) ? 2'b11 : 2'($urandom)};
                send_txn(OP_WRITE, REG_START, pick_lane(), d);
            end
            else if (pick < 70)
            begin
                n = $urandom_range(4, 64);
                repeat (n)
                    send_txn(OP_TICK, 3'($urandom), 2'($urandom), 16'($urandom));
            end
            else if (pick < 85)
            begin
                // interrupt service: read status, then acknowledge
                send_txn(OP_READ, ch ? REG_CSR1 : REG_CSR0, pick_lane(), 16'($urandom));
                n = $urandom_range(0, 2);
                repeat (n)
                    send_txn(OP_TICK, 3'($urandom), 2'($urandom), 16'($urandom));
                d = {8'($urandom), ($urandom_range(0, 9) == 0), 1'($urandom),
                     4'($urandom), pick_cs()};
                send_txn(OP_WRITE, ch ? REG_CSR1 : REG_CSR0, pick_lane(), d);
            end
            else if (pick < 95)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_txn(OP_READ, 3'($urandom), 2'($urandom), 16'($urandom));
            end
            else
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    send_txn(2'($urandom), 3'($urandom), 2'($urandom), 16'($urandom));
            end
        end

        wait_drained(2000);
        repeat (20) @(posedge clk);
        sb.flush_leftovers();

        $display("%0d transactions: %0d ticks, %0d reads, %0d writes, %0d no-ops",
                 sent_count, sb.n_ticks, sb.n_reads, sb.n_writes, sb.n_other);
        $display("%0d responses checked, %0d compare matches, %0d flag clears, %0d errors",
                 sb.n_checked, sb.n_matches, sb.n_clears, sb.n_errors);
        if (sb.n_errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
